// ----- rtl/phcr_pkg.sv -----
package phcr_pkg;

  // Event codes as they appear on the result channel.
  localparam logic [2:0] EV_LEAVE  = 3'd0;
  localparam logic [2:0] EV_ENTER  = 3'd1;
  localparam logic [2:0] EV_MOVE   = 3'd2;
  localparam logic [2:0] EV_DOWN   = 3'd3;
  localparam logic [2:0] EV_UP     = 3'd4;
  localparam logic [2:0] EV_CLICK  = 3'd5;
  localparam logic [2:0] EV_CANCEL = 3'd6;

  // Request types.
  localparam logic REQ_UPDATE = 1'b0;
  localparam logic REQ_CANCEL = 1'b1;

  // Bit positions of the pending-event mask, lowest first in emission order.
  localparam int SLOT_CAP_CANCEL = 0;  // cancel request: capture cancel
  localparam int SLOT_LEAVE      = 1;
  localparam int SLOT_ENTER      = 2;
  localparam int SLOT_MOVE       = 3;
  localparam int SLOT_DOWN       = 4;
  localparam int SLOT_UP         = 5;
  localparam int SLOT_CLICK      = 6;
  localparam int SLOT_REL_CANCEL = 7;  // release off the captured surface
  localparam int NUM_SLOTS       = 8;

  typedef logic [NUM_SLOTS-1:0] phcr_mask_t;

  typedef struct packed {
    logic        req_type;
    logic [3:0]  source_id;
    logic        contact_hit;
    logic [1:0]  contact_surface;
    logic [15:0] contact_x;
    logic [15:0] contact_y;
    logic        button_down;
  } phcr_in_t;

  typedef struct packed {
    logic [2:0]  event_kind;
    logic [3:0]  event_source;
    logic [1:0]  event_surface;
    logic [15:0] event_x;
    logic [15:0] event_y;
    logic        last_event;
  } phcr_out_t;

  // Stored surface and pixel of a hover or capture entry.
  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] x;
    logic [15:0] y;
  } phcr_entry_t;

  // Controller to datapath.
  typedef struct packed {
    logic load;
    logic eval;
    logic emit;
  } phcr_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic any_event;
    logic last_pending;
  } phcr_sts_t;

  function automatic logic [2:0] slot_kind(input logic [2:0] slot);
    logic [2:0] k;
    case (slot)
      3'(SLOT_CAP_CANCEL): k = EV_CANCEL;
      3'(SLOT_LEAVE):      k = EV_LEAVE;
      3'(SLOT_ENTER):      k = EV_ENTER;
      3'(SLOT_MOVE):       k = EV_MOVE;
      3'(SLOT_DOWN):       k = EV_DOWN;
      3'(SLOT_UP):         k = EV_UP;
      3'(SLOT_CLICK):      k = EV_CLICK;
      3'(SLOT_REL_CANCEL): k = EV_CANCEL;
      default:             k = EV_CANCEL;
    endcase
    return k;
  endfunction

endpackage

// ----- rtl/phcr_ctrl.sv -----
module phcr_ctrl
  import phcr_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  input  phcr_sts_t sts,
  output phcr_cmd_t cmd,
  output logic      busy
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_EVAL = 2'd1;
  localparam logic [1:0] ST_EMIT = 2'd2;

  logic [1:0] state_r;
  logic [1:0] state_nxt;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (start) state_nxt = ST_EVAL;
      end
      ST_EVAL: begin
        state_nxt = sts.any_event ? ST_EMIT : ST_IDLE;
      end
      ST_EMIT: begin
        if (sts.last_pending) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign cmd.load = (state_r == ST_IDLE) && start;
  assign cmd.eval = (state_r == ST_EVAL);
  assign cmd.emit = (state_r == ST_EMIT);
  assign busy     = (state_r != ST_IDLE);

endmodule

// ----- rtl/phcr_datapath.sv -----
module phcr_datapath
  import phcr_pkg::*;
#(
  parameter int NUM_SOURCES = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  input  phcr_cmd_t cmd,
  input  phcr_in_t  in_data,
  output phcr_sts_t sts,
  output logic      out_valid,
  output phcr_out_t out_data
);

  localparam int IDX_W = (NUM_SOURCES > 1) ? $clog2(NUM_SOURCES) : 1;

  // Surface and pixel stores; only read behind their active flags.
  phcr_entry_t hov_mem [NUM_SOURCES];
  phcr_entry_t cap_mem [NUM_SOURCES];

  logic [NUM_SOURCES-1:0] hov_act_r;
  logic [NUM_SOURCES-1:0] btn_was_r;
  logic [NUM_SOURCES-1:0] cap_act_r;

  phcr_in_t    req_r;
  phcr_entry_t hov_rd_r;
  phcr_entry_t cap_rd_r;
  phcr_mask_t  mask_r;
  phcr_mask_t  mask_nxt;

  logic [IDX_W-1:0] ld_idx;
  logic [IDX_W-1:0] idx;
  logic             in_ok;
  logic             ha, bw, ca;
  logic             hit, pressed, same, press, rel, on_cap;
  logic             is_upd, is_cncl;
  phcr_mask_t       ev_mask;
  phcr_entry_t      cur;

  assign ld_idx = IDX_W'(in_data.source_id);
  assign idx    = IDX_W'(req_r.source_id);
  assign in_ok  = {28'd0, req_r.source_id} < 32'(NUM_SOURCES);

  assign cur = '{kind: req_r.contact_surface, x: req_r.contact_x, y: req_r.contact_y};

  // Event decision for the item held in req_r.
  always_comb begin
    ha      = hov_act_r[idx];
    bw      = btn_was_r[idx];
    ca      = cap_act_r[idx];
    hit     = req_r.contact_hit;
    pressed = req_r.button_down;
    is_upd  = in_ok && (req_r.req_type == REQ_UPDATE);
    is_cncl = in_ok && (req_r.req_type == REQ_CANCEL);
    same    = ha && hit && (hov_rd_r.kind == req_r.contact_surface);
    press   = pressed && !bw;
    rel     = !pressed && bw && ca;
    on_cap  = hit && (req_r.contact_surface == cap_rd_r.kind);

    ev_mask                  = '0;
    ev_mask[SLOT_CAP_CANCEL] = is_cncl && ca;
    ev_mask[SLOT_LEAVE]      = (is_cncl && ha) || (is_upd && ha && !same);
    ev_mask[SLOT_ENTER]      = is_upd && hit && !same;
    ev_mask[SLOT_MOVE]       = is_upd && hit;
    ev_mask[SLOT_DOWN]       = is_upd && press && hit;
    ev_mask[SLOT_UP]         = is_upd && rel && on_cap;
    ev_mask[SLOT_CLICK]      = is_upd && rel && on_cap;
    ev_mask[SLOT_REL_CANCEL] = is_upd && rel && !on_cap;
  end

  // Lowest pending slot goes out first.
  logic [2:0]  slot;
  phcr_mask_t  slot_oh;
  phcr_mask_t  rest;
  phcr_entry_t ev_ent;

  always_comb begin
    slot    = '0;
    slot_oh = '0;
    for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
      if (mask_r[i]) begin
        slot    = 3'(i);
        slot_oh = phcr_mask_t'(1) << i;
      end
    end
    rest = mask_r & ~slot_oh;
    case (slot)
      3'(SLOT_CAP_CANCEL): ev_ent = cap_rd_r;
      3'(SLOT_REL_CANCEL): ev_ent = cap_rd_r;
      3'(SLOT_LEAVE):      ev_ent = hov_rd_r;
      default:             ev_ent = cur;
    endcase
  end

  always_comb begin
    mask_nxt = mask_r;
    if (cmd.eval) begin
      mask_nxt = ev_mask;
    end else if (cmd.emit) begin
      mask_nxt = rest;
    end
  end

  assign sts.any_event    = |ev_mask;
  assign sts.last_pending = (rest == '0);

  assign out_valid              = cmd.emit;
  assign out_data.event_kind    = slot_kind(slot);
  assign out_data.event_source  = req_r.source_id;
  assign out_data.event_surface = ev_ent.kind;
  assign out_data.event_x       = ev_ent.x;
  assign out_data.event_y       = ev_ent.y;
  assign out_data.last_event    = (rest == '0);

  // Payload registers and stores.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_r    <= in_data;
      hov_rd_r <= hov_mem[ld_idx];
      cap_rd_r <= cap_mem[ld_idx];
    end
    if (cmd.eval && is_upd && hit) begin
      hov_mem[idx] <= cur;
    end
    if (cmd.eval && is_upd && press && hit) begin
      cap_mem[idx] <= cur;
    end
  end

  // Per-source flags and the pending mask.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hov_act_r <= '0;
      btn_was_r <= '0;
      cap_act_r <= '0;
      mask_r    <= '0;
    end else begin
      mask_r <= mask_nxt;
      if (cmd.eval && is_cncl) begin
        hov_act_r[idx] <= 1'b0;
        btn_was_r[idx] <= 1'b0;
        cap_act_r[idx] <= 1'b0;
      end else if (cmd.eval && is_upd) begin
        hov_act_r[idx] <= hit;
        btn_was_r[idx] <= pressed;
        if (press && hit) begin
          cap_act_r[idx] <= 1'b1;
        end else if (rel) begin
          cap_act_r[idx] <= 1'b0;
        end
      end
    end
  end

endmodule

// ----- rtl/pointer_hover_capture_router_core.sv -----
// Pointer hover and capture router.
// An item is offered on in_data with start and is taken at a rising edge at
// which start is high and busy is low. The item names a pointer source; the
// block keeps hover, button and capture state for every source and turns the
// item into a burst of zero to five events on out_data, one beat per cycle,
// each marked by out_valid for exactly one cycle. The final beat of a burst
// carries last_event. An item whose source is NUM_SOURCES or above gives no beat.
// The cycle after acceptance reads the source's entry and decides the events;
// the first beat follows in the next cycle, and the beats then run one per
// cycle, as set by the registered table read and the one-event-per-cycle
// output sequencer.
// busy stays high from acceptance until the last beat has gone.
// Reset (synchronous, rst_n low) clears every hover, button and capture flag at
// once; stored surfaces and pixels need no clearing, as they are read only
// behind their flags. The receiver cannot stall: every beat must be taken in
// the cycle it is shown.
module pointer_hover_capture_router_core
  import phcr_pkg::*;
#(
  parameter int NUM_SOURCES = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  phcr_in_t  in_data,
  output logic      out_valid,
  output phcr_out_t out_data
);

  phcr_cmd_t cmd;
  phcr_sts_t sts;

  // The controller sequences load, decision and emission; it knows nothing of
  // the table contents and sees only whether events remain.
  phcr_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy)
  );

  // The datapath holds the per-source table, decides the event mask and
  // drives one beat per emission cycle, lowest pending event first.
  phcr_datapath #(
    .NUM_SOURCES (NUM_SOURCES)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .in_data   (in_data),
    .sts       (sts),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

// ----- rtl/phcr_checker.sv -----
module phcr_checker
  import phcr_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      start,
  input logic      busy,
  input logic      out_valid,
  input phcr_out_t out_data
);

  // Beats only appear while an item is in hand.
  a_beat_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy)
    else $error("beat shown while idle");

  // The cycle after acceptance is spent deciding; no beat may appear yet.
  a_accept_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (busy && !out_valid))
    else $error("no decision cycle after acceptance");

  // The final beat releases the block at once.
  a_last_frees: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.last_event) |=> (!out_valid && !busy))
    else $error("block still busy after final beat");

  // A burst runs without gaps until its final beat.
  a_burst_dense: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.last_event) |=>
      (out_valid && (out_data.event_source == $past(out_data.event_source))))
    else $error("burst broken or source changed mid-burst");

endmodule

bind pointer_hover_capture_router_core phcr_checker u_phcr_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid),
  .out_data  (out_data)
);
